FILE: hw/rtl/single_wire_brightness_sender_core_defines.svh
// ----------------------------------------------------------------------------
// Single-wire brightness sender: assertion macros
// Shared concurrent assertion forms used by the sender's top level.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_BRIGHTNESS_SENDER_CORE_DEFINES_SVH
`define SINGLE_WIRE_BRIGHTNESS_SENDER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SWBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swbs_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender: shared package
// Types, codes and constants used by the sender's modules.
// ----------------------------------------------------------------------------
package swbs_pkg;

    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SHUTDOWN_SLOTS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd1;

    localparam logic [7:0] SHUTDOWN_SLOTS_RST = 8'd45;
    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h72;

    // Input action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [4:0] LEVEL_MAX = 5'd31;
    localparam logic [7:0] DATA_CMD  = 8'h40;

    // Init pattern, slot i of the pattern is bit i: high,high,low x5,high.
    localparam logic [7:0] INIT_PATTERN = 8'b1000_0011;
    localparam logic [7:0] INIT_SLOTS   = 8'd8;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b000_0001,
        PH_SHUT  = 7'b000_0010,
        PH_INIT  = 7'b000_0100,
        PH_ABITS = 7'b000_1000,
        PH_AEOS  = 7'b001_0000,
        PH_DBITS = 7'b010_0000,
        PH_DEOS  = 7'b100_0000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] slot_count;
        logic [2:0] bit_index;
        logic [1:0] slot_in_bit;
        logic [7:0] shift_byte;
        logic [7:0] data_byte;
        logic       level_out;
    } state_t;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic done;
    } result_t;

    typedef struct packed {
        logic [7:0] shutdown_slots;
        logic [7:0] device_address;
    } cfg_t;

endpackage

FILE: hw/rtl/single_wire_brightness_sender_core.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender core
// Slot-by-slot transmitter for a one-wire brightness control line.
// ----------------------------------------------------------------------------
// A start beat (action 0) latches a brightness level, saturated to 31, and
// arms the sequence; each tick beat (action 1) drives one slot and returns
// the line level for it. The sequence holds the line low for shutdown_slots
// slots (0 acts as 1), sends high,high, five lows and a high, then the
// address byte and the data byte (0x40 OR level), MSB first, one bit in four
// slots, each byte closed by low,high; after that the line rests high. Every
// input beat yields exactly one result beat. The block takes one beat per
// clock cycle while results drain; an accepted beat lands in the input
// register and moves through the slot step logic into the result register
// once that register is empty or draining. The result register lets a new
// beat be taken while an earlier result still waits on out_ready.
// device_address is sampled when the address byte begins. Configuration
// writes are always ready and should be issued only while the sender has
// no beats in flight.
// ----------------------------------------------------------------------------
`include "single_wire_brightness_sender_core_defines.svh"

module single_wire_brightness_sender_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [7:0]                        brightness,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              line_level,
    output logic                              busy_res,
    output logic                              done_res
);
    import swbs_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;

    // Input register.
    logic       in_valid_reg;
    logic       action_reg;
    logic [7:0] brightness_reg;

    // Result register.
    logic       out_valid_reg;
    result_t    res_reg;

    logic       advance;

    swbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held beat moves on when the result register is empty or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            action_reg     <= ACT_TICK;
            brightness_reg <= 8'd0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg   <= 1'b1;
            action_reg     <= action;
            brightness_reg <= brightness;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    swbs_step u_step (
        .cur        (state_reg),
        .action     (action_reg),
        .brightness (brightness_reg),
        .cfg        (cfg),
        .nxt        (state_next),
        .res        (step_res)
    );

    // Sequencer state advances only when a beat is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.slot_count  <= 8'd0;
            state_reg.bit_index   <= 3'd0;
            state_reg.slot_in_bit <= 2'd0;
            state_reg.shift_byte  <= 8'd0;
            state_reg.data_byte   <= 8'd0;
            state_reg.level_out   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            res_reg       <= step_res;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = res_reg.line_level;
    assign busy_res   = res_reg.busy;
    assign done_res   = res_reg.done;

    // A final slot must leave the sequencer idle.
    `SWBS_ASSERT_NEXT(a_done_goes_idle, advance && step_res.done,
        state_reg.phase == PH_IDLE,
        "done slot did not return to idle")

    // A start beat always rearms the shutdown hold from its first slot.
    `SWBS_ASSERT_NEXT(a_start_arms, advance && (action_reg == ACT_START),
        (state_reg.phase == PH_SHUT) && (state_reg.slot_count == 8'd0),
        "start beat did not arm the shutdown hold")

    // A held beat that cannot move on stays held.
    `SWBS_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && !advance,
        in_valid_reg && $stable(action_reg) && $stable(brightness_reg),
        "held input beat was lost")

endmodule

FILE: hw/rtl/swbs_cfg.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender: configuration registers
// Decodes register writes into the shutdown length and device address.
// ----------------------------------------------------------------------------
module swbs_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                        cfg_data,
    output swbs_pkg::cfg_t                    cfg
);
    import swbs_pkg::*;

    logic [7:0] shutdown_slots_reg;
    logic [7:0] device_address_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shutdown_slots_reg <= SHUTDOWN_SLOTS_RST;
            device_address_reg <= DEVICE_ADDRESS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SHUTDOWN_SLOTS: shutdown_slots_reg <= cfg_data;
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign cfg.shutdown_slots = shutdown_slots_reg;
    assign cfg.device_address = device_address_reg;

endmodule

FILE: hw/rtl/swbs_step.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender: slot step logic
// Computes the next sequencer state and the result for one item.
// ----------------------------------------------------------------------------
module swbs_step (
    input  swbs_pkg::state_t  cur,
    input  logic              action,
    input  logic [7:0]        brightness,
    input  swbs_pkg::cfg_t    cfg,
    output swbs_pkg::state_t  nxt,
    output swbs_pkg::result_t res
);
    import swbs_pkg::*;

    logic [4:0] level;
    logic [7:0] shut_len;
    logic [7:0] count_inc;
    logic       bit_one;
    logic       bit_level;
    logic       byte_done;

    assign level     = (brightness > {3'b000, LEVEL_MAX}) ? LEVEL_MAX : brightness[4:0];
    assign shut_len  = (cfg.shutdown_slots == 8'd0) ? 8'd1 : cfg.shutdown_slots;
    assign count_inc = cur.slot_count + 8'd1;
    assign bit_one   = cur.shift_byte[7];
    // A one is low,high,high,high; a zero is low,low,low,high.
    assign bit_level = (cur.slot_in_bit == 2'd0) ? 1'b0
                     : (bit_one ? 1'b1 : (cur.slot_in_bit == 2'd3));
    assign byte_done = (cur.slot_in_bit == 2'd3) && (cur.bit_index == 3'd7);

    always_comb
    begin
        nxt      = cur;
        res.busy = 1'b1;
        res.done = 1'b0;
        if (action == ACT_START)
        begin
            nxt.data_byte   = DATA_CMD | {3'b000, level};
            nxt.phase       = PH_SHUT;
            nxt.slot_count  = 8'd0;
            nxt.bit_index   = 3'd0;
            nxt.slot_in_bit = 2'd0;
        end
        else
        begin
            unique case (cur.phase)
                PH_SHUT:
                begin
                    nxt.level_out  = 1'b0;
                    nxt.slot_count = count_inc;
                    if (count_inc >= shut_len)
                    begin
                        nxt.phase      = PH_INIT;
                        nxt.slot_count = 8'd0;
                    end
                end
                PH_INIT:
                begin
                    nxt.level_out  = INIT_PATTERN[cur.slot_count[2:0]];
                    nxt.slot_count = count_inc;
                    if (count_inc >= INIT_SLOTS)
                    begin
                        nxt.slot_count  = 8'd0;
                        nxt.phase       = PH_ABITS;
                        nxt.shift_byte  = cfg.device_address;
                        nxt.bit_index   = 3'd0;
                        nxt.slot_in_bit = 2'd0;
                    end
                end
                PH_ABITS, PH_DBITS:
                begin
                    nxt.level_out   = bit_level;
                    nxt.slot_in_bit = cur.slot_in_bit + 2'd1;
                    if (cur.slot_in_bit == 2'd3)
                    begin
                        nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                        nxt.bit_index  = cur.bit_index + 3'd1;
                    end
                    if (byte_done)
                    begin
                        nxt.phase = (cur.phase == PH_ABITS) ? PH_AEOS : PH_DEOS;
                    end
                end
                PH_AEOS, PH_DEOS:
                begin
                    // End of byte: low then high.
                    nxt.level_out = cur.slot_in_bit[0];
                    if (cur.slot_in_bit == 2'd0)
                    begin
                        nxt.slot_in_bit = 2'd1;
                    end
                    else if (cur.phase == PH_AEOS)
                    begin
                        nxt.phase       = PH_DBITS;
                        nxt.shift_byte  = cur.data_byte;
                        nxt.bit_index   = 3'd0;
                        nxt.slot_in_bit = 2'd0;
                    end
                    else
                    begin
                        nxt.phase       = PH_IDLE;
                        nxt.slot_in_bit = 2'd0;
                        res.done        = 1'b1;
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                    res.busy  = 1'b0;
                end
            endcase
        end
        res.line_level = nxt.level_out;
    end

endmodule

FILE: sim/single_wire_brightness_sender_checker.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender: scoreboard
// Watches the config, input and result channels of the sender, predicts the
// line level and status of every slot, and compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module single_wire_brightness_sender_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [swbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             action,
    input  logic [7:0]                       brightness,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             line_level,
    input  logic                             busy_res,
    input  logic                             done_res,
    output int                               fail_count,
    output int                               owed_count
);
    import swbs_pkg::*;

    // Shadow copy of the sender's registers and sequencing state.
    cfg_t       regs;
    phase_t     ph;
    logic [7:0] slot_cnt;
    logic [2:0] bit_pos;
    logic [1:0] sub_slot;
    logic [7:0] shift_reg;
    logic [7:0] data_reg;
    logic       wire_lvl;

    result_t    owed_slots[$];

    // Advances the shadow state by one input beat and returns the slot result.
    function result_t advance_slot(input logic act, input logic [7:0] lvl);
        result_t    r;
        logic [7:0] hold;
        r.busy = 1'b1;
        r.done = 1'b0;
        if (act == ACT_START)
        begin
            data_reg = DATA_CMD | ((lvl > {3'b000, LEVEL_MAX}) ? {3'b000, LEVEL_MAX} : lvl);
            ph       = PH_SHUT;
            slot_cnt = 8'd0;
            bit_pos  = 3'd0;
            sub_slot = 2'd0;
        end
        else
        begin
            case (ph)
                PH_SHUT:
                begin
                    hold     = (regs.shutdown_slots == 8'd0) ? 8'd1 : regs.shutdown_slots;
                    wire_lvl = 1'b0;
                    slot_cnt = slot_cnt + 8'd1;
                    if (slot_cnt >= hold)
                    begin
                        ph       = PH_INIT;
                        slot_cnt = 8'd0;
                    end
                end
                PH_INIT:
                begin
                    wire_lvl = INIT_PATTERN[slot_cnt[2:0]];
                    slot_cnt = slot_cnt + 8'd1;
                    if (slot_cnt >= INIT_SLOTS)
                    begin
                        slot_cnt  = 8'd0;
                        ph        = PH_ABITS;
                        shift_reg = regs.device_address;
                        bit_pos   = 3'd0;
                        sub_slot  = 2'd0;
                    end
                end
                PH_ABITS, PH_DBITS:
                begin
                    // Four slots per bit: low first, high last, the middle
                    // two carry the bit value.
                    if (sub_slot == 2'd0)
                        wire_lvl = 1'b0;
                    else if (shift_reg[7])
                        wire_lvl = 1'b1;
                    else
                        wire_lvl = (sub_slot == 2'd3);
                    sub_slot = sub_slot + 2'd1;
                    if (sub_slot == 2'd0)
                    begin
                        shift_reg = shift_reg << 1;
                        if (bit_pos == 3'd7)
                        begin
                            bit_pos = 3'd0;
                            ph      = (ph == PH_ABITS) ? PH_AEOS : PH_DEOS;
                        end
                        else
                            bit_pos = bit_pos + 3'd1;
                    end
                end
                PH_AEOS, PH_DEOS:
                begin
                    wire_lvl = sub_slot[0];
                    if (sub_slot == 2'd0)
                        sub_slot = 2'd1;
                    else if (ph == PH_AEOS)
                    begin
                        ph        = PH_DBITS;
                        shift_reg = data_reg;
                        bit_pos   = 3'd0;
                        sub_slot  = 2'd0;
                    end
                    else
                    begin
                        ph       = PH_IDLE;
                        sub_slot = 2'd0;
                        r.done   = 1'b1;
                    end
                end
                default:
                begin
                    ph     = PH_IDLE;
                    r.busy = 1'b0;
                end
            endcase
        end
        r.line_level = wire_lvl;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            regs.shutdown_slots = SHUTDOWN_SLOTS_RST;
            regs.device_address = DEVICE_ADDRESS_RST;
            ph         = PH_IDLE;
            slot_cnt   = 8'd0;
            bit_pos    = 3'd0;
            sub_slot   = 2'd0;
            shift_reg  = 8'd0;
            data_reg   = 8'd0;
            wire_lvl   = 1'b0;
            fail_count = 0;
            owed_slots.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SHUTDOWN_SLOTS)
                    regs.shutdown_slots = cfg_data;
                else if (cfg_index == CFG_DEVICE_ADDRESS)
                    regs.device_address = cfg_data;
            end
            if (in_valid && in_ready)
                owed_slots.push_back(advance_slot(action, brightness));
            if (out_valid && out_ready)
            begin
                got = {line_level, busy_res, done_res};
                if (owed_slots.size() == 0)
                begin
                    $error("result beat arrived with no slot predicted");
                    fail_count++;
                end
                else
                begin
                    want = owed_slots.pop_front();
                    if (got.line_level !== want.line_level)
                    begin
                        $error("line_level: expected %0b, got %0b",
                               want.line_level, got.line_level);
                        fail_count++;
                    end
                    if (got.busy !== want.busy)
                    begin
                        $error("busy_res: expected %0b, got %0b", want.busy, got.busy);
                        fail_count++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("done_res: expected %0b, got %0b", want.done, got.done);
                        fail_count++;
                    end
                end
            end
        end
        owed_count = owed_slots.size();
    end

endmodule

FILE: sim/tb_single_wire_brightness_sender_core.sv
// ----------------------------------------------------------------------------
// Single-wire brightness sender: testbench top
// Drives start and tick beats through the sender under several register
// settings, with random idling on both channels, and reports the verdict
// from the scoreboard's failure and outstanding counts.
// ----------------------------------------------------------------------------
module tb_single_wire_brightness_sender_core;
    import swbs_pkg::*;

    // Index past the end of the register map; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Settling margin after every predicted result has been seen.
    localparam int SETTLE      = 4;
    // Upper bound on cycles spent waiting for outstanding results.
    localparam int DRAIN_LIMIT = 4000;
    // Length of the one long receiver hold-off that backs the sender up.
    localparam int LONG_HOLD   = 120;
    // Ticks a full transfer takes beyond its shutdown hold: eight init
    // slots, then two bytes of 32 bit slots plus two end-of-byte slots each.
    localparam int SEQ_TAIL    = 76;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   action;
    logic [7:0]             brightness;
    logic                   out_valid;
    logic                   out_ready;
    logic                   line_level;
    logic                   busy_res;
    logic                   done_res;

    int fail_count;
    int owed_count;

    // Stimulus knobs shared between the sender and receiver processes.
    int cur_hold;     // effective shutdown hold of the current setting
    int gap_pct;      // chance in percent of an idle burst before a beat
    bit calm;         // set for the closing phase: nobody idles any more
    bit hold_req;     // asks the receiver for its long hold-off
    bit hold_served;  // the receiver has done the long hold-off

    single_wire_brightness_sender_core DUT (.*);

    single_wire_brightness_sender_checker scoreboard (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // The run must never get this far; if it does, something hung.
    initial
    begin
        #(8_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side. It alternates ready stretches with stall bursts, and on
    // request holds out_ready low for a long stretch so that the sender's
    // internal registers fill and in_ready drops while beats are on offer.
    initial
    begin : receiver
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offers one input beat and returns at the edge where it is taken.
    // It must be entered right after a rising edge. An idle burst may come
    // first; valid is only dropped here, never in the same step as a raise.
    task automatic send_beat(input logic act, input logic [7:0] lvl);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        brightness <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_beat(ACT_TICK, 8'($urandom));
    endtask

    // Stops offering beats and waits until every predicted result has been
    // seen, then lets the pipeline settle. The count is read on the falling
    // edge, away from the scoreboard's updates on the rising edge.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (owed_count != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes both registers back to back, plus a stray write to the unmapped
    // index, then drops cfg_valid. Only called with nothing in flight.
    task automatic set_config(input logic [7:0] shut, input logic [7:0] addr);
        write_reg(CFG_SHUTDOWN_SLOTS, shut);
        write_reg(CFG_DEVICE_ADDRESS, addr);
        write_reg(CFG_UNMAPPED, 8'($urandom));
        cfg_valid <= 1'b0;
        cur_hold = (shut == 8'd0) ? 1 : int'(shut);
    endtask

    // Random traffic. Most of it is whole transfers (a start followed by
    // enough ticks to finish and idle a little), some are transfers cut
    // short by the next start, and the rest is loose noise beats.
    task automatic run_random(input int count);
        int sent;
        int kind;
        int n;
        int k;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 9)
            begin
                if (kind < 7)
                    n = cur_hold + SEQ_TAIL + $urandom_range(0, 3);
                else
                    n = $urandom_range(1, cur_hold + SEQ_TAIL - 1);
                send_beat(ACT_START, $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                          : 8'($urandom_range(0, 255)));
                sent++;
                for (k = 0; k < n && sent < count; k++)
                begin
                    send_beat(ACT_TICK, 8'($urandom));
                    sent++;
                end
            end
            else
            begin
                for (k = $urandom_range(1, 5); k > 0 && sent < count; k--)
                begin
                    send_beat(1'($urandom_range(0, 1)), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_SHUTDOWN_SLOTS;
        cfg_data    <= 8'd0;
        in_valid    <= 1'b0;
        action      <= ACT_TICK;
        brightness  <= 8'd0;
        cur_hold    = int'(SHUTDOWN_SLOTS_RST);
        gap_pct     = 20;
        calm        = 1'b0;
        hold_req    = 1'b0;
        hold_served = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset register values. Ticks straight after
        // reset must report a low line and no activity.
        send_beat(ACT_TICK, 8'hFF);
        send_beat(ACT_TICK, 8'h00);
        // Start with the top level; it has to saturate to 31.
        send_beat(ACT_START, 8'hFF);
        run_ticks(3);
        // Restart while busy, with the smallest level that still saturates.
        send_beat(ACT_START, 8'd32);
        run_ticks(2);
        // Restart again with level zero; this is the transfer that finishes.
        send_beat(ACT_START, 8'd0);
        run_ticks(4);
        // The transfer is still in its shutdown hold. Changing the address
        // now must show up in the address byte, since it is sampled only
        // when that byte begins.
        drain_results();
        set_config(SHUTDOWN_SLOTS_RST, 8'h00);
        // Finish the transfer and keep ticking into idle: line rests high.
        run_ticks(int'(SHUTDOWN_SLOTS_RST) + SEQ_TAIL - 1);
        drain_results();

        // A zero shutdown length must act as one; all-ones address.
        set_config(8'd0, 8'hFF);
        gap_pct = 20;
        run_random(160);
        drain_results();

        // Longest shutdown hold with an all-zeros address.
        set_config(8'd255, 8'h00);
        gap_pct = 10;
        run_random(340);
        drain_results();

        // Random settings. One phase runs without sender gaps, one carries
        // the long receiver hold-off, and the last has no idling at all.
        for (p = 0; p < 5; p++)
        begin
            set_config(8'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
            gap_pct  = (p == 1) ? 0 : 25;
            hold_req = (p == 2);
            calm     = (p == 4);
            run_random(140);
            drain_results();
        end

        if (owed_count != 0)
            $error("%0d predicted results never arrived", owed_count);
        if (fail_count == 0 && owed_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
